### hw/rtl/mgfo_pkg.sv
// ----------------------------------------------------------------------------
// mgfo_pkg
// Shared types and constants for the moving glow frame overlay pipeline.
// ----------------------------------------------------------------------------
package mgfo_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // register indexes
    localparam logic [2:0] REG_WIDTH     = 3'd0;
    localparam logic [2:0] REG_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_PATH_MODE = 3'd2;
    localparam logic [2:0] REG_BLEND     = 3'd3;
    localparam logic [2:0] REG_HEAD_POS  = 3'd4;
    localparam logic [2:0] REG_HEAD_LEN  = 3'd5;
    localparam logic [2:0] REG_THICKNESS = 3'd6;
    localparam logic [2:0] REG_COLOR     = 3'd7;

    localparam logic PATH_PERIMETER = 1'b0;
    localparam logic PATH_ROWS      = 1'b1;
    localparam logic BLEND_NORMAL   = 1'b0;
    localparam logic BLEND_ADD      = 1'b1;

    localparam int PATH_W = 16;   // point index / path length width
    localparam int DIST_W = 32;   // distance with 16 fraction bits

    typedef struct packed {
        logic [13:0] width;       // saturated W
        logic [13:0] height;      // saturated H
        logic        path_mode;
        logic        blend_mode;
        logic [15:0] head_position;
        logic [13:0] head_length; // zero replaced by one
        logic [6:0]  reach;
        logic [31:0] color;
    } cfg_t;

    typedef struct packed {
        logic              hit;
        logic [PATH_W-1:0] idx;
    } point_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pix_t;

    // floor(v / 255) for v < 65280
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        begin
            t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
            div255 = t[15:8];
        end
    endfunction

endpackage

### hw/rtl/mgfo_locate.sv
// ----------------------------------------------------------------------------
// mgfo_locate
// Stage 1: find the up to four path points that cover a pixel.
// ----------------------------------------------------------------------------
module mgfo_locate
(
    input  logic              clk,
    input  logic              rst_n,
    input  mgfo_pkg::cfg_t    cfg,
    input  logic              in_valid,
    input  logic [11:0]       x,
    input  logic [11:0]       y,
    input  mgfo_pkg::pix_t    in_pix,
    output logic              out_valid,
    output mgfo_pkg::point_t  pts [4],
    output logic [mgfo_pkg::PATH_W-1:0] n_out,
    output mgfo_pkg::pix_t    out_pix
);

    logic [13:0] w, h, xe, ye, rch;
    logic [15:0] n_next;
    logic        frame_ok;
    mgfo_pkg::point_t pts_next [4];

    // classify the pixel against each path segment
    always_comb
    begin
        w   = cfg.width;
        h   = cfg.height;
        xe  = {2'd0, x};
        ye  = {2'd0, y};
        rch = {7'd0, cfg.reach};
        for (int k = 0; k < 4; k++)
        begin
            pts_next[k] = '0;
        end
        n_next   = '0;
        frame_ok = (xe < w) && (ye < h);
        if (cfg.path_mode == mgfo_pkg::PATH_PERIMETER)
        begin
            n_next = 16'({w - 14'd1, 1'b0}) + 16'({h - 14'd1, 1'b0});
            if (frame_ok && w >= 14'd2 && h >= 14'd2)
            begin
                pts_next[0].hit = (xe <= w - 14'd2) && (ye <= rch);
                pts_next[0].idx = 16'(xe);
                pts_next[1].hit = (ye <= h - 14'd2) && (w - 14'd1 - xe <= rch);
                pts_next[1].idx = 16'(w - 14'd1) + 16'(ye);
                pts_next[2].hit = (xe >= 14'd1) && (h - 14'd1 - ye <= rch);
                pts_next[2].idx = 16'(w - 14'd1) + 16'(h - 14'd1) + 16'(w - 14'd1 - xe);
                pts_next[3].hit = (ye >= 14'd1) && (xe <= rch);
                pts_next[3].idx = 16'({w - 14'd1, 1'b0}) + 16'(h - 14'd1)
                                + 16'(h - 14'd1 - ye);
            end
        end
        else
        begin
            n_next = 16'({w, 1'b0});
            if (frame_ok && w >= 14'd2 && h >= 14'd1)
            begin
                pts_next[0].hit = (ye <= rch);
                pts_next[0].idx = 16'(xe);
                pts_next[1].hit = (h - 14'd1 - ye <= rch);
                pts_next[1].idx = 16'(w) + 16'(xe);
            end
        end
    end

    // advance valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= in_valid;
    end

    // hold payload
    always_ff @(posedge clk)
    begin
        pts     <= pts_next;
        n_out   <= n_next;
        out_pix <= in_pix;
    end

endmodule

### hw/rtl/mgfo_alpha.sv
// ----------------------------------------------------------------------------
// mgfo_alpha
// Four stages: distance behind head, peak multiply and a two-stage divide
// giving the rounded alpha for one path point.
// ----------------------------------------------------------------------------
module mgfo_alpha
(
    input  logic                        clk,
    input  mgfo_pkg::cfg_t              cfg,
    input  mgfo_pkg::point_t            pt,
    input  logic [mgfo_pkg::PATH_W-1:0] n,
    input  logic [mgfo_pkg::DIST_W-1:0] head,
    output logic [7:0]                  ai
);

    logic [31:0] pos, d, den, num_s1, den_s1, den_s2;
    logic        ok_s1, ok_s2, ok_s3;
    logic [7:0]  peak;
    logic [40:0] prod_s2;
    logic [41:0] twice, den2_s2, rem_hi, rem_s3, den2_s3, rem_lo;
    logic [7:0]  q_hi, q_s3, q_lo;

    // distance behind the head, wrapped
    always_comb
    begin
        pos  = {pt.idx, 16'd0};
        den  = {2'd0, cfg.head_length, 16'd0};
        peak = cfg.color[7:0];
        if (head >= pos)
            d = head - pos;
        else
            d = head + {n, 16'd0} - pos;
    end

    // hold numerator
    always_ff @(posedge clk)
    begin
        ok_s1  <= pt.hit && (d <= den);
        num_s1 <= den - d;
        den_s1 <= den;
    end

    // scale by peak
    always_ff @(posedge clk)
    begin
        prod_s2 <= 41'(num_s1) * 41'(peak);
        ok_s2   <= ok_s1;
        den_s2  <= den_s1;
    end

    // round half up: divide 2*peak*num + den by 2*den, upper four quotient bits;
    // num <= den keeps the quotient below 256
    always_comb
    begin
        den2_s2 = {9'd0, den_s2, 1'b0};
        twice   = {prod_s2, 1'b0} + {10'd0, den_s2};
        rem_hi  = twice;
        q_hi    = 8'd0;
        for (int b = 7; b >= 4; b--)
        begin
            if (rem_hi >= (den2_s2 << b))
            begin
                rem_hi  = rem_hi - (den2_s2 << b);
                q_hi[b] = 1'b1;
            end
        end
    end

    // hold partial remainder
    always_ff @(posedge clk)
    begin
        rem_s3  <= rem_hi;
        q_s3    <= q_hi;
        den2_s3 <= den2_s2;
        ok_s3   <= ok_s2;
    end

    // lower four quotient bits
    always_comb
    begin
        rem_lo = rem_s3;
        q_lo   = q_s3;
        for (int b = 3; b >= 0; b--)
        begin
            if (rem_lo >= (den2_s3 << b))
            begin
                rem_lo  = rem_lo - (den2_s3 << b);
                q_lo[b] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ai <= ok_s3 ? q_lo : 8'd0;
    end

endmodule

### hw/rtl/mgfo_blend.sv
// ----------------------------------------------------------------------------
// mgfo_blend
// One blend stage: apply one contribution to the pixel, registered.
// ----------------------------------------------------------------------------
module mgfo_blend
(
    input  logic           clk,
    input  logic           blend_mode,
    input  logic [31:0]    color,
    input  logic [7:0]     ai,
    input  mgfo_pkg::pix_t in_pix,
    output mgfo_pkg::pix_t out_pix
);

    mgfo_pkg::pix_t res;

    function automatic logic [7:0] mix(input logic mode, input logic [7:0] g,
                                       input logic [7:0] c, input logic [7:0] a);
        logic [15:0] p;
        logic [8:0]  s;
        begin
            if (mode == mgfo_pkg::BLEND_ADD)
            begin
                s   = {1'b0, c} + {1'b0, mgfo_pkg::div255(16'(g) * 16'(a))};
                mix = s[8] ? 8'hFF : s[7:0];
            end
            else
            begin
                p   = 16'(g) * 16'(a) + 16'(c) * 16'(8'hFF - a);
                mix = mgfo_pkg::div255(p);
            end
        end
    endfunction

    // blend channels, saturate alpha
    always_comb
    begin
        logic [8:0] sa;
        sa  = {1'b0, in_pix.a} + {1'b0, ai};
        res = in_pix;
        if (ai != 8'd0)
        begin
            res.r = mix(blend_mode, color[31:24], in_pix.r, ai);
            res.g = mix(blend_mode, color[23:16], in_pix.g, ai);
            res.b = mix(blend_mode, color[15:8],  in_pix.b, ai);
            res.a = sa[8] ? 8'hFF : sa[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        out_pix <= res;
    end

endmodule

### hw/rtl/moving_glow_frame_overlay.sv
// ----------------------------------------------------------------------------
// moving_glow_frame_overlay
// Blends a moving glow band along the frame path into a pixel stream.
// ----------------------------------------------------------------------------
// Usage: drive pixel_x, pixel_y and the input channels with start high; a
// request is taken at every rising edge with start high (busy is tied low, so
// one pixel per clock). Ten register stages, the first loaded at the accepting
// edge: locate, head multiply, four alpha stages (distance, peak multiply, two
// divider stages) and four blend stages, one per path point in path order.
// The result shows on out_* with done high for one cycle. Throughput is one
// pixel per cycle with no gaps. The receiver cannot stall; done is a strobe.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write only while no request is in flight (the block does not check). Reset
// clears the valid chain and returns registers to W=2, H=2, head_length=1,
// thickness=1, all else zero. Writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
module moving_glow_frame_overlay
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic [7:0]  in_alpha,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha
);

    logic [12:0] width_reg, height_reg;
    logic        path_reg, blend_reg;
    logic [15:0] head_pos_reg;
    logic [13:0] head_len_reg;
    logic [7:0]  thick_reg;
    logic [31:0] color_reg;
    logic [31:0] head_reg;
    mgfo_pkg::cfg_t cfg;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 13'd2;
            height_reg   <= 13'd2;
            path_reg     <= mgfo_pkg::PATH_PERIMETER;
            blend_reg    <= mgfo_pkg::BLEND_NORMAL;
            head_pos_reg <= '0;
            head_len_reg <= 14'd1;
            thick_reg    <= 8'd1;
            color_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mgfo_pkg::REG_WIDTH:     width_reg    <= cfg_data[12:0];
                mgfo_pkg::REG_HEIGHT:    height_reg   <= cfg_data[12:0];
                mgfo_pkg::REG_PATH_MODE: path_reg     <= cfg_data[0];
                mgfo_pkg::REG_BLEND:     blend_reg    <= cfg_data[0];
                mgfo_pkg::REG_HEAD_POS:  head_pos_reg <= cfg_data[15:0];
                mgfo_pkg::REG_HEAD_LEN:  head_len_reg <= cfg_data[13:0];
                mgfo_pkg::REG_THICKNESS: thick_reg    <= cfg_data[7:0];
                mgfo_pkg::REG_COLOR:     color_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // derive working configuration
    always_comb
    begin
        logic [7:0] span;
        span = (thick_reg == 8'd0) ? 8'd1 : thick_reg;
        cfg.width  = (width_reg > 13'(mgfo_pkg::MAX_WIDTH)) ? 14'(mgfo_pkg::MAX_WIDTH)
                                                             : {1'b0, width_reg};
        cfg.height = (height_reg > 13'(mgfo_pkg::MAX_HEIGHT)) ? 14'(mgfo_pkg::MAX_HEIGHT)
                                                               : {1'b0, height_reg};
        cfg.path_mode     = path_reg;
        cfg.blend_mode    = blend_reg;
        cfg.head_position = head_pos_reg;
        cfg.head_length   = (head_len_reg == 14'd0) ? 14'd1 : head_len_reg;
        cfg.reach         = 7'((span - 8'd1) >> 1);
        cfg.color         = color_reg;
    end

    // stage 1: locate points
    logic             v1;
    mgfo_pkg::point_t pts [4];
    logic [15:0]      n1;
    mgfo_pkg::pix_t   pix1, pix_in;
    assign pix_in = '{r: in_red, g: in_green, b: in_blue, a: in_alpha};
    assign busy   = 1'b0;

    mgfo_locate u_locate (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_valid(start && !busy),
        .x(pixel_x), .y(pixel_y), .in_pix(pix_in),
        .out_valid(v1), .pts(pts), .n_out(n1), .out_pix(pix1));

    // head position on the path, registered alongside the point delay after stage 1
    always_ff @(posedge clk)
    begin
        head_reg <= 32'(head_pos_reg) * 32'(n1);
    end

    // stage 1 -> alpha: align points with head product
    mgfo_pkg::point_t pts_d [4];
    logic [15:0]      n_d;
    always_ff @(posedge clk)
    begin
        pts_d <= pts;
        n_d   <= n1;
    end

    logic [7:0] ai [4];
    for (genvar k = 0; k < 4; k++)
    begin : g_alpha
        mgfo_alpha u_alpha (.clk(clk), .cfg(cfg), .pt(pts_d[k]), .n(n_d),
                            .head(head_reg), .ai(ai[k]));
    end

    // delay pixel through alpha stages (head + 4)
    mgfo_pkg::pix_t pix_q [5];
    always_ff @(posedge clk)
    begin
        pix_q[0] <= pix1;
        for (int i = 1; i < 5; i++)
            pix_q[i] <= pix_q[i-1];
    end

    // delay alphas so each blend stage sees its own point
    logic [7:0] ai1_d, ai2_d [2], ai3_d [3];
    always_ff @(posedge clk)
    begin
        ai1_d    <= ai[1];
        ai2_d[0] <= ai[2];
        ai2_d[1] <= ai2_d[0];
        ai3_d[0] <= ai[3];
        ai3_d[1] <= ai3_d[0];
        ai3_d[2] <= ai3_d[1];
    end

    mgfo_pkg::pix_t b0, b1, b2, b3;
    mgfo_blend u_b0 (.clk(clk), .blend_mode(blend_reg), .color(color_reg),
                     .ai(ai[0]), .in_pix(pix_q[4]), .out_pix(b0));
    mgfo_blend u_b1 (.clk(clk), .blend_mode(blend_reg), .color(color_reg),
                     .ai(ai1_d), .in_pix(b0), .out_pix(b1));
    mgfo_blend u_b2 (.clk(clk), .blend_mode(blend_reg), .color(color_reg),
                     .ai(ai2_d[1]), .in_pix(b1), .out_pix(b2));
    mgfo_blend u_b3 (.clk(clk), .blend_mode(blend_reg), .color(color_reg),
                     .ai(ai3_d[2]), .in_pix(b2), .out_pix(b3));

    // advance valid chain to the output
    logic [8:0] vq;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq <= '0;
        else
            vq <= {vq[7:0], v1};
    end

    assign done      = vq[8];
    assign out_red   = b3.r;
    assign out_green = b3.g;
    assign out_blue  = b3.b;
    assign out_alpha = b3.a;

    // every request taken is seen as done once it leaves the last blend stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##10 done)
        else $error("done missing ten cycles after request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 10))
        else $error("done without request");

endmodule
